[hdl/ptmm_pkg.sv]
package ptmm_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 10;
    localparam int RING_AW      = $clog2(WINDOW_DEPTH);

    // Field widths.
    localparam int RAW_W      = 16;
    localparam int SAMPLE_W   = 14;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int CONV_W     = RAW_W + 2;
    localparam int TYPE_W     = 1;
    localparam int LIMIT_W    = 13;
    localparam int TIMER_W    = 6;
    localparam int FAIL_W     = 4;

    // Serial divider: dividend magnitude and divisor widths, two quotient bits per cycle.
    localparam int DIV_W      = 20;
    localparam int DVS_W      = 6;
    localparam int DIV_STEPS  = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SENSOR_TYPE   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_OVER_LIMIT    = cfg_idx_t'(1);
    localparam cfg_idx_t REG_REPOWER_TICKS = cfg_idx_t'(2);
    localparam cfg_idx_t REG_FAIL_LIMIT    = cfg_idx_t'(3);

    // Register reset values.
    localparam logic [TYPE_W-1:0]  SENSOR_TYPE_RST  = 1'b0;
    localparam logic [LIMIT_W-1:0] OVER_LIMIT_RST   = 13'd800;
    localparam logic [TIMER_W-1:0] REPOWER_RST      = 6'd10;
    localparam logic [FAIL_W-1:0]  FAIL_LIMIT_RST   = 4'd3;
    localparam logic [FAIL_W-1:0]  FAIL_MAX         = 4'hF;

    // Sensor error codes.
    localparam logic [RAW_W-1:0] RAW_ERR_LOW  = 16'h0000;
    localparam logic [RAW_W-1:0] RAW_ERR_HIGH = 16'hFFFF;

    // Conversion: type 0 is 2*(raw-16500)/27, type 1 is 7*(raw-10714)/54.
    localparam logic signed [CONV_W-1:0] CONV0_OFFSET = 18'sd16500;
    localparam logic signed [CONV_W-1:0] CONV1_OFFSET = 18'sd10714;
    localparam logic [DVS_W-1:0]         CONV0_DEN    = 6'd27;
    localparam logic [DVS_W-1:0]         CONV1_DEN    = 6'd54;
    localparam logic [DVS_W-1:0]         MEAN_DEN     = DVS_W'(WINDOW_DEPTH - 2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [RING_AW-1:0]         ring_addr_t;

    // Divider request and response.
    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic    done;
        sample_t quotient;
    } div_rsp_t;

    // Sample window control and status.
    typedef struct packed {
        logic       wr_en;
        ring_addr_t wr_addr;
        sample_t    wr_data;
        logic       walk_start;
    } win_ctrl_t;

    typedef struct packed {
        logic done;
        sum_t trimmed;
    } win_stat_t;

endpackage

[hdl/ptmm_if.sv]
// Sensor read request channel.
interface ptmm_in_if;
    logic                           valid;
    logic                           ready;
    logic                           ack;
    logic [ptmm_pkg::RAW_W-1:0]     raw_code;

    modport source (output valid, output ack, output raw_code, input ready);
    modport sink (input valid, input ack, input raw_code, output ready);
endinterface

// Filtered result channel.
interface ptmm_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [ptmm_pkg::SAMPLE_W-1:0] pressure;
    logic                           pressure_valid;
    logic                           read_error;
    logic                           overpressure;

    modport source (output valid, output pressure, output pressure_valid,
                    output read_error, output overpressure, input ready);
    modport sink (input valid, input pressure, input pressure_valid,
                  input read_error, input overpressure, output ready);
endinterface

// Configuration write channel.
interface ptmm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ptmm_pkg::CFG_IDX_W-1:0]    index;
    logic [ptmm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/ptmm_serial_div.sv]
module ptmm_serial_div (
    input  logic               clk,
    input  logic               rst_n,
    input  ptmm_pkg::div_req_t req,
    output ptmm_pkg::div_rsp_t rsp
);

    logic [ptmm_pkg::DIV_W-1:0]     quo_reg;
    logic [ptmm_pkg::DIV_W-1:0]     quo_next;
    logic [ptmm_pkg::DVS_W-1:0]     rem_reg;
    logic [ptmm_pkg::DVS_W-1:0]     rem_next;
    logic [ptmm_pkg::DVS_W-1:0]     dvs_reg;
    logic                           neg_reg;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [ptmm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [ptmm_pkg::DIV_CNT_W-1:0] cnt_next;

    logic [ptmm_pkg::DIV_W-1:0]     start_mag;
    logic [ptmm_pkg::DVS_W:0]       trial_a;
    logic [ptmm_pkg::DVS_W:0]       trial_b;
    logic [ptmm_pkg::DVS_W:0]       diff_a;
    logic [ptmm_pkg::DVS_W:0]       diff_b;
    logic [ptmm_pkg::DVS_W-1:0]     rem_a;
    logic                           ge_a;
    logic                           ge_b;
    logic [ptmm_pkg::DIV_W-1:0]     result_mag;

    // Magnitude of the signed dividend; quotient sign is restored at the end.
    assign start_mag = req.dividend[ptmm_pkg::DIV_W-1]
                       ? ptmm_pkg::DIV_W'(-req.dividend)
                       : ptmm_pkg::DIV_W'(req.dividend);

    // Two restoring steps per cycle, dividend bits shifted out of the top of quo_reg.
    always_comb
    begin
        trial_a  = {rem_reg, quo_reg[ptmm_pkg::DIV_W-1]};
        diff_a   = trial_a - {1'b0, dvs_reg};
        ge_a     = (trial_a >= {1'b0, dvs_reg});
        rem_a    = ge_a ? diff_a[ptmm_pkg::DVS_W-1:0] : trial_a[ptmm_pkg::DVS_W-1:0];
        trial_b  = {rem_a, quo_reg[ptmm_pkg::DIV_W-2]};
        diff_b   = trial_b - {1'b0, dvs_reg};
        ge_b     = (trial_b >= {1'b0, dvs_reg});
        rem_next = ge_b ? diff_b[ptmm_pkg::DVS_W-1:0] : trial_b[ptmm_pkg::DVS_W-1:0];
        quo_next = {quo_reg[ptmm_pkg::DIV_W-3:0], ge_a, ge_b};
    end

    // Step counter and completion pulse.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = ptmm_pkg::DIV_CNT_W'(ptmm_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= start_mag;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.dividend[ptmm_pkg::DIV_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Truncation toward zero: negate the magnitude quotient for a negative dividend.
    assign result_mag   = neg_reg ? ptmm_pkg::DIV_W'(-quo_reg) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = ptmm_pkg::sample_t'(result_mag[ptmm_pkg::SAMPLE_W-1:0]);

endmodule

[hdl/ptmm_window.sv]
module ptmm_window (
    input  logic                clk,
    input  logic                rst_n,
    input  ptmm_pkg::win_ctrl_t ctrl,
    output ptmm_pkg::win_stat_t stat
);

    ptmm_pkg::sample_t    ring_mem [ptmm_pkg::WINDOW_DEPTH];
    ptmm_pkg::sample_t    rd_data_reg;

    logic                 busy_reg;
    logic                 busy_next;
    ptmm_pkg::ring_addr_t rd_addr_reg;
    ptmm_pkg::ring_addr_t rd_addr_next;
    logic                 rd_vld_reg;
    logic                 rd_vld_next;
    logic                 rd_last_reg;
    logic                 rd_last_next;
    logic                 first_reg;
    logic                 first_next;
    logic                 done_reg;
    logic                 done_next;

    ptmm_pkg::sum_t       sum_reg;
    ptmm_pkg::sample_t    lo_reg;
    ptmm_pkg::sample_t    hi_reg;

    logic                 at_last;

    assign at_last = (rd_addr_reg == ptmm_pkg::RING_AW'(ptmm_pkg::WINDOW_DEPTH - 1));

    // Sample store: one write port, one registered read port for the walk.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            ring_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        rd_data_reg <= ring_mem[rd_addr_reg];
    end

    // Walk sequencer over all entries; the read address wraps back to entry zero.
    always_comb
    begin
        busy_next    = busy_reg;
        rd_addr_next = rd_addr_reg;
        rd_vld_next  = 1'b0;
        rd_last_next = 1'b0;
        first_next   = first_reg;
        done_next    = rd_vld_reg && rd_last_reg;
        if (ctrl.walk_start)
        begin
            busy_next    = 1'b1;
            rd_addr_next = '0;
            first_next   = 1'b1;
        end
        else
        begin
            if (busy_reg)
            begin
                rd_vld_next  = 1'b1;
                rd_last_next = at_last;
                rd_addr_next = at_last ? '0 : rd_addr_reg + 1'b1;
                if (at_last)
                begin
                    busy_next = 1'b0;
                end
            end
            if (rd_vld_reg)
            begin
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            rd_addr_reg <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            first_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            rd_addr_reg <= rd_addr_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            first_reg   <= first_next;
            done_reg    <= done_next;
        end
    end

    // Running sum, minimum and maximum, one sample per cycle.
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if (first_reg)
            begin
                sum_reg <= ptmm_pkg::SUM_W'(rd_data_reg);
                lo_reg  <= rd_data_reg;
                hi_reg  <= rd_data_reg;
            end
            else
            begin
                sum_reg <= sum_reg + ptmm_pkg::SUM_W'(rd_data_reg);
                if (rd_data_reg < lo_reg)
                begin
                    lo_reg <= rd_data_reg;
                end
                if (rd_data_reg > hi_reg)
                begin
                    hi_reg <= rd_data_reg;
                end
            end
        end
    end

    assign stat.done    = done_reg;
    assign stat.trimmed = sum_reg - ptmm_pkg::SUM_W'(lo_reg) - ptmm_pkg::SUM_W'(hi_reg);

endmodule

[hdl/pressure_trimmed_mean_monitor_top.sv]
// Channel  | Modport | Payload                                              | Handshake
// sensor   | sink    | ack, raw_code[15:0]                                  | valid/ready
// result   | source  | pressure[13:0] signed, pressure_valid, read_error,   | valid/ready
//          |         | overpressure                                         |
// cfg      | sink    | index[3:0], data[15:0]; ready is always high         | valid/ready
//
// One request is in work at a time. Power-off ticks, missing acknowledges and error codes
// go from acceptance straight to ST_DONE. A good read while the window fills runs only the
// conversion; once it is full, the serial divider (2 quotient bits per cycle) runs for the
// conversion and again for the mean, with a walk between them that reads one stored sample
// per cycle. A result waits in the output register; the next finished result stalls in
// ST_DONE until it leaves. Reset is async, low.
module pressure_trimmed_mean_monitor_top (
    input logic          clk,
    input logic          rst_n,
    ptmm_in_if.sink      sensor,
    ptmm_out_if.source   result,
    ptmm_cfg_if.sink     cfg
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_WALK = 5'b00100,
        ST_MEAN = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;

    // Configuration registers.
    logic [ptmm_pkg::TYPE_W-1:0]           sensor_type_reg;
    logic [ptmm_pkg::LIMIT_W-1:0]          over_limit_reg;
    logic [ptmm_pkg::TIMER_W-1:0]          repower_reg;
    logic [ptmm_pkg::FAIL_W-1:0]           fail_limit_reg;

    // Monitor state.
    logic                                  powered_reg;
    logic                                  powered_next;
    logic [ptmm_pkg::TIMER_W-1:0]          off_timer_reg;
    logic [ptmm_pkg::TIMER_W-1:0]          off_timer_next;
    logic [ptmm_pkg::FAIL_W-1:0]           fail_count_reg;
    logic [ptmm_pkg::FAIL_W-1:0]           fail_count_next;
    ptmm_pkg::ring_addr_t                  ring_idx_reg;
    ptmm_pkg::ring_addr_t                  ring_idx_next;
    logic                                  ring_full_reg;
    logic                                  ring_full_next;
    ptmm_pkg::sample_t                     held_pressure_reg;
    ptmm_pkg::sample_t                     held_pressure_next;
    logic                                  held_valid_reg;
    logic                                  held_valid_next;
    logic                                  over_flag_reg;
    logic                                  over_flag_next;
    logic                                  err_reg;
    logic                                  err_next;

    // Output register.
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    ptmm_pkg::sample_t                     out_pressure_reg;
    logic                                  out_pvalid_reg;
    logic                                  out_err_reg;
    logic                                  out_over_reg;

    ptmm_pkg::div_req_t                    div_req;
    ptmm_pkg::div_rsp_t                    div_rsp;
    ptmm_pkg::win_ctrl_t                   win_ctrl;
    ptmm_pkg::win_stat_t                   win_stat;

    logic                                  accept;
    logic                                  load_out;
    logic                                  raw_bad;
    logic [ptmm_pkg::FAIL_W-1:0]           fail_inc;
    logic signed [ptmm_pkg::CONV_W-1:0]    conv_d;
    logic signed [ptmm_pkg::DIV_W-1:0]     conv_ext;
    logic signed [ptmm_pkg::DIV_W-1:0]     conv_num;
    logic                                  wrap;
    logic                                  over_hit;

    assign accept   = sensor.valid && sensor.ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    assign raw_bad  = (sensor.raw_code == ptmm_pkg::RAW_ERR_LOW)
                      || (sensor.raw_code == ptmm_pkg::RAW_ERR_HIGH);
    assign fail_inc = (fail_count_reg == ptmm_pkg::FAIL_MAX)
                      ? ptmm_pkg::FAIL_MAX : fail_count_reg + 1'b1;
    assign wrap     = (ring_idx_reg == ptmm_pkg::RING_AW'(ptmm_pkg::WINDOW_DEPTH - 1));
    assign over_hit = held_valid_reg
                      && (held_pressure_reg > $signed({1'b0, over_limit_reg}));

    // Conversion numerator: 2*(raw-16500) or 7*(raw-10714).
    always_comb
    begin
        conv_d   = $signed({2'b00, sensor.raw_code})
                   - (sensor_type_reg[0] ? ptmm_pkg::CONV1_OFFSET : ptmm_pkg::CONV0_OFFSET);
        conv_ext = ptmm_pkg::DIV_W'(conv_d);
        conv_num = sensor_type_reg[0] ? (conv_ext <<< 3) - conv_ext : conv_ext <<< 1;
    end

    // Shared divider: conversion at acceptance, trimmed mean after the walk.
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = conv_num;
        div_req.divisor  = sensor_type_reg[0] ? ptmm_pkg::CONV1_DEN : ptmm_pkg::CONV0_DEN;
        if (state_reg == ST_WALK)
        begin
            div_req.dividend = ptmm_pkg::DIV_W'(win_stat.trimmed);
            div_req.divisor  = ptmm_pkg::MEAN_DEN;
            div_req.start    = win_stat.done;
        end
        else if (accept && powered_reg && sensor.ack && !raw_bad)
        begin
            div_req.start = 1'b1;
        end
    end

    // Main sequencer and state update.
    always_comb
    begin
        state_next         = state_reg;
        powered_next       = powered_reg;
        off_timer_next     = off_timer_reg;
        fail_count_next    = fail_count_reg;
        ring_idx_next      = ring_idx_reg;
        ring_full_next     = ring_full_reg;
        held_pressure_next = held_pressure_reg;
        held_valid_next    = held_valid_reg;
        over_flag_next     = over_flag_reg;
        err_next           = err_reg;
        win_ctrl.wr_en      = 1'b0;
        win_ctrl.wr_addr    = ring_idx_reg;
        win_ctrl.wr_data    = div_rsp.quotient;
        win_ctrl.walk_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    err_next   = 1'b0;
                    state_next = ST_DONE;
                    priority if (!powered_reg)
                    begin
                        if (off_timer_reg <= ptmm_pkg::TIMER_W'(1))
                        begin
                            off_timer_next  = '0;
                            ring_idx_next   = '0;
                            ring_full_next  = 1'b0;
                            held_valid_next = 1'b0;
                            powered_next    = 1'b1;
                        end
                        else
                        begin
                            off_timer_next = off_timer_reg - 1'b1;
                        end
                    end
                    else if (!sensor.ack)
                    begin
                        held_valid_next = 1'b0;
                        err_next        = 1'b1;
                    end
                    else if (raw_bad)
                    begin
                        powered_next    = 1'b0;
                        off_timer_next  = repower_reg;
                        fail_count_next = fail_inc;
                        if (fail_inc > fail_limit_reg)
                        begin
                            held_valid_next = 1'b0;
                            err_next        = 1'b1;
                        end
                    end
                    else
                    begin
                        fail_count_next = '0;
                        state_next      = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (div_rsp.done)
                begin
                    win_ctrl.wr_en = 1'b1;
                    ring_idx_next  = wrap ? '0 : ring_idx_reg + 1'b1;
                    ring_full_next = ring_full_reg || wrap;
                    if (ring_full_reg || wrap)
                    begin
                        win_ctrl.walk_start = 1'b1;
                        state_next          = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK:
            begin
                if (win_stat.done)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (div_rsp.done)
                begin
                    held_pressure_next = div_rsp.quotient;
                    held_valid_next    = 1'b1;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    over_flag_next = over_flag_reg || over_hit;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register hand-off.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            powered_reg       <= 1'b0;
            off_timer_reg     <= '0;
            fail_count_reg    <= '0;
            ring_idx_reg      <= '0;
            ring_full_reg     <= 1'b0;
            held_pressure_reg <= '0;
            held_valid_reg    <= 1'b0;
            over_flag_reg     <= 1'b0;
            err_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            powered_reg       <= powered_next;
            off_timer_reg     <= off_timer_next;
            fail_count_reg    <= fail_count_next;
            ring_idx_reg      <= ring_idx_next;
            ring_full_reg     <= ring_full_next;
            held_pressure_reg <= held_pressure_next;
            held_valid_reg    <= held_valid_next;
            over_flag_reg     <= over_flag_next;
            err_reg           <= err_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload; pressure reads zero while not valid.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_pressure_reg <= held_valid_reg ? held_pressure_reg : '0;
            out_pvalid_reg   <= held_valid_reg;
            out_err_reg      <= err_reg;
            out_over_reg     <= over_flag_reg || over_hit;
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_type_reg <= ptmm_pkg::SENSOR_TYPE_RST;
            over_limit_reg  <= ptmm_pkg::OVER_LIMIT_RST;
            repower_reg     <= ptmm_pkg::REPOWER_RST;
            fail_limit_reg  <= ptmm_pkg::FAIL_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ptmm_pkg::REG_SENSOR_TYPE:
                    sensor_type_reg <= cfg.data[ptmm_pkg::TYPE_W-1:0];
                ptmm_pkg::REG_OVER_LIMIT:
                    over_limit_reg <= cfg.data[ptmm_pkg::LIMIT_W-1:0];
                ptmm_pkg::REG_REPOWER_TICKS:
                    repower_reg <= cfg.data[ptmm_pkg::TIMER_W-1:0];
                ptmm_pkg::REG_FAIL_LIMIT:
                    fail_limit_reg <= cfg.data[ptmm_pkg::FAIL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ready    = 1'b1;
    assign sensor.ready = (state_reg == ST_IDLE);

    assign result.valid          = out_valid_reg;
    assign result.pressure       = out_pressure_reg;
    assign result.pressure_valid = out_pvalid_reg;
    assign result.read_error     = out_err_reg;
    assign result.overpressure   = out_over_reg;

    ptmm_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ptmm_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (win_ctrl),
        .stat  (win_stat)
    );

endmodule

[hdl/ptmm_checker.sv]
module ptmm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [ptmm_pkg::SAMPLE_W-1:0] out_pressure,
    input logic                              out_pressure_valid,
    input logic                              out_read_error,
    input logic                              out_overpressure
);

    // A stalled result keeps its place and its pressure value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pressure))
        else $error("result dropped or changed while stalled");

    // Only one request is in work: the sensor side closes right after a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while one is in work");

    // An invalid pressure reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_pressure_valid |-> out_pressure == '0)
        else $error("invalid pressure is not zero");

    // A read error always comes with an invalid pressure.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_read_error |-> !out_pressure_valid)
        else $error("read error reported with valid pressure");

    // The overpressure flag stays set once shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_overpressure |=> !out_valid || out_overpressure)
        else $error("overpressure flag cleared");

endmodule

bind pressure_trimmed_mean_monitor_top ptmm_checker u_ptmm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (sensor.valid),
    .in_ready           (sensor.ready),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .out_pressure       (result.pressure),
    .out_pressure_valid (result.pressure_valid),
    .out_read_error     (result.read_error),
    .out_overpressure   (result.overpressure)
);
